/* hw/rtl/hsvc_pkg.sv */
// Shared types and constants for the random HSV to RGB colour generator.
package hsvc_pkg;

  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_HUE_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HUE_HIGH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SAT_LOW    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SAT_HIGH   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_VALUE_LOW  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_VALUE_HIGH = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_VARY_VALUE = 3'd6;

  localparam int unsigned DEG_W   = 9;
  localparam int unsigned CHAN_W  = 16;
  localparam int unsigned SPAN_W  = 6;

  localparam logic [DEG_W-1:0]  DEG_60  = 9'd60;
  localparam logic [DEG_W-1:0]  DEG_120 = 9'd120;
  localparam logic [DEG_W-1:0]  DEG_180 = 9'd180;
  localparam logic [DEG_W-1:0]  DEG_240 = 9'd240;
  localparam logic [DEG_W-1:0]  DEG_300 = 9'd300;
  localparam logic [DEG_W-1:0]  DEG_360 = 9'd360;
  localparam logic [SPAN_W-1:0] SPAN_60 = 6'd60;

  localparam logic [CHAN_W-1:0] CHAN_SCALE = 16'd65280;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } hsvc_sector_e;

endpackage

/* hw/rtl/random_hsv_color_to_rgb_top.sv */
// Random HSV colour generator top level: three random fractions in, one RGB colour out.
//
// Input channel: in_valid_i with draw_hue_i, draw_sat_i and draw_value_i; a request
// is taken at a rising edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o with red_o, green_o and blue_o in unsigned 8.8;
// a request leaves at an edge where out_valid_o is high and out_stall_i is low.
// Configuration: cfg_valid_i, cfg_index_i, cfg_data_i; cfg_ready_o is always high,
// so every write is accepted. Write only while no request is in flight.
// Six register stages: three for range mapping, hue degrees, chroma and the X product,
// three for the divide by sixty, channel assembly and 8.8 scaling. One request is
// taken every cycle while in_stall_o is low.
// A stalled receiver holds the output register; bubbles further back still close
// up, so in_stall_o rises only once every stage holds a request.
// Reset empties the pipeline and loads the default colour ranges.
module random_hsv_color_to_rgb_top
  import hsvc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FRAC_BITS-1:0] draw_hue_i,
  input  logic [FRAC_BITS-1:0] draw_sat_i,
  input  logic [FRAC_BITS-1:0] draw_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CHAN_W-1:0]    red_o,
  output logic [CHAN_W-1:0]    green_o,
  output logic [CHAN_W-1:0]    blue_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [FRAC_BITS:0]   cfg_data_i
);

  logic [FRAC_BITS:0]   hue_lo, hue_span, sat_lo, sat_span, val_lo, val_span, val_top;
  logic                 vary;
  logic                 front_ready, front_valid, back_ready;
  logic [FRAC_BITS+6:0] prod;
  logic [FRAC_BITS:0]   chroma, base;
  hsvc_sector_e         sector;

  hsvc_cfg #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .hue_lo_o   (hue_lo),
    .hue_span_o (hue_span),
    .sat_lo_o   (sat_lo),
    .sat_span_o (sat_span),
    .val_lo_o   (val_lo),
    .val_span_o (val_span),
    .val_top_o  (val_top),
    .vary_o     (vary)
  );

  hsvc_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (front_ready),
    .draw_hue_i  (draw_hue_i),
    .draw_sat_i  (draw_sat_i),
    .draw_value_i(draw_value_i),
    .hue_lo_i    (hue_lo),
    .hue_span_i  (hue_span),
    .sat_lo_i    (sat_lo),
    .sat_span_i  (sat_span),
    .val_lo_i    (val_lo),
    .val_span_i  (val_span),
    .val_top_i   (val_top),
    .vary_i      (vary),
    .valid_o     (front_valid),
    .ready_i     (back_ready),
    .prod_o      (prod),
    .chroma_o    (chroma),
    .base_o      (base),
    .sector_o    (sector)
  );

  hsvc_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .ready_o (back_ready),
    .prod_i  (prod),
    .chroma_i(chroma),
    .base_i  (base),
    .sector_i(sector),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  assign in_stall_o = !front_ready;

endmodule

/* hw/rtl/hsvc_cfg.sv */
// Configuration registers with clamped, ordered range bounds for the mapping stage.
module hsvc_cfg
  import hsvc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [FRAC_BITS:0]   cfg_data_i,
  output logic [FRAC_BITS:0]   hue_lo_o,
  output logic [FRAC_BITS:0]   hue_span_o,
  output logic [FRAC_BITS:0]   sat_lo_o,
  output logic [FRAC_BITS:0]   sat_span_o,
  output logic [FRAC_BITS:0]   val_lo_o,
  output logic [FRAC_BITS:0]   val_span_o,
  output logic [FRAC_BITS:0]   val_top_o,
  output logic                 vary_o
);

  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned ONE_I = 1 << F;
  localparam logic [F:0] ONE    = {1'b1, {F{1'b0}}};

  localparam logic [F:0] T1 = (F+1)'((ONE_I * 1 + 5) / 10);
  localparam logic [F:0] T5 = (F+1)'((ONE_I * 5 + 5) / 10);
  localparam logic [F:0] T6 = (F+1)'((ONE_I * 6 + 5) / 10);
  localparam logic [F:0] T8 = (F+1)'((ONE_I * 8 + 5) / 10);
  localparam logic [F:0] T9 = (F+1)'((ONE_I * 9 + 5) / 10);

  logic [F:0] hue_low_q, hue_low_d, hue_high_q, hue_high_d;
  logic [F:0] sat_low_q, sat_low_d, sat_high_q, sat_high_d;
  logic [F:0] val_low_q, val_low_d, val_high_q, val_high_d;
  logic       vary_q, vary_d;

  logic [F:0] hue_lo_q, hue_lo_d, hue_span_q, hue_span_d;
  logic [F:0] sat_lo_q, sat_lo_d, sat_span_q, sat_span_d;
  logic [F:0] val_lo_q, val_lo_d, val_span_q, val_span_d;
  logic [F:0] val_top_q, val_top_d;

  function automatic logic [F:0] sat_one(input logic [F:0] v);
    sat_one = (v > ONE) ? ONE : v;
  endfunction

  function automatic logic [F:0] lower_of(input logic [F:0] a, input logic [F:0] b);
    logic [F:0] sa;
    logic [F:0] sb;
    sa = sat_one(a);
    sb = sat_one(b);
    lower_of = (sa > sb) ? sb : sa;
  endfunction

  function automatic logic [F:0] upper_of(input logic [F:0] a, input logic [F:0] b);
    logic [F:0] sa;
    logic [F:0] sb;
    sa = sat_one(a);
    sb = sat_one(b);
    upper_of = (sa > sb) ? sa : sb;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_comb begin
    hue_low_d  = hue_low_q;
    hue_high_d = hue_high_q;
    sat_low_d  = sat_low_q;
    sat_high_d = sat_high_q;
    val_low_d  = val_low_q;
    val_high_d = val_high_q;
    vary_d     = vary_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HUE_LOW:    hue_low_d  = cfg_data_i;
        REG_HUE_HIGH:   hue_high_d = cfg_data_i;
        REG_SAT_LOW:    sat_low_d  = cfg_data_i;
        REG_SAT_HIGH:   sat_high_d = cfg_data_i;
        REG_VALUE_LOW:  val_low_d  = cfg_data_i;
        REG_VALUE_HIGH: val_high_d = cfg_data_i;
        REG_VARY_VALUE: vary_d     = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hue_lo_d   = lower_of(hue_low_d, hue_high_d);
    hue_span_d = upper_of(hue_low_d, hue_high_d) - hue_lo_d;
    sat_lo_d   = lower_of(sat_low_d, sat_high_d);
    sat_span_d = upper_of(sat_low_d, sat_high_d) - sat_lo_d;
    val_lo_d   = lower_of(val_low_d, val_high_d);
    val_top_d  = upper_of(val_low_d, val_high_d);
    val_span_d = val_top_d - val_lo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q  <= T1;
      hue_high_q <= T9;
      sat_low_q  <= T5;
      sat_high_q <= ONE;
      val_low_q  <= T6;
      val_high_q <= T8;
      vary_q     <= 1'b0;
      hue_lo_q   <= T1;
      hue_span_q <= T9 - T1;
      sat_lo_q   <= T5;
      sat_span_q <= ONE - T5;
      val_lo_q   <= T6;
      val_span_q <= T8 - T6;
      val_top_q  <= T8;
    end else begin
      hue_low_q  <= hue_low_d;
      hue_high_q <= hue_high_d;
      sat_low_q  <= sat_low_d;
      sat_high_q <= sat_high_d;
      val_low_q  <= val_low_d;
      val_high_q <= val_high_d;
      vary_q     <= vary_d;
      hue_lo_q   <= hue_lo_d;
      hue_span_q <= hue_span_d;
      sat_lo_q   <= sat_lo_d;
      sat_span_q <= sat_span_d;
      val_lo_q   <= val_lo_d;
      val_span_q <= val_span_d;
      val_top_q  <= val_top_d;
    end
  end

  assign hue_lo_o   = hue_lo_q;
  assign hue_span_o = hue_span_q;
  assign sat_lo_o   = sat_lo_q;
  assign sat_span_o = sat_span_q;
  assign val_lo_o   = val_lo_q;
  assign val_span_o = val_span_q;
  assign val_top_o  = val_top_q;
  assign vary_o     = vary_q;

endmodule

/* hw/rtl/hsvc_front.sv */
// Front pipeline: range mapping, hue degrees and chroma, sector and X product.
module hsvc_front
  import hsvc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [FRAC_BITS-1:0]   draw_hue_i,
  input  logic [FRAC_BITS-1:0]   draw_sat_i,
  input  logic [FRAC_BITS-1:0]   draw_value_i,
  input  logic [FRAC_BITS:0]     hue_lo_i,
  input  logic [FRAC_BITS:0]     hue_span_i,
  input  logic [FRAC_BITS:0]     sat_lo_i,
  input  logic [FRAC_BITS:0]     sat_span_i,
  input  logic [FRAC_BITS:0]     val_lo_i,
  input  logic [FRAC_BITS:0]     val_span_i,
  input  logic [FRAC_BITS:0]     val_top_i,
  input  logic                   vary_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [FRAC_BITS+6:0]   prod_o,
  output logic [FRAC_BITS:0]     chroma_o,
  output logic [FRAC_BITS:0]     base_o,
  output hsvc_sector_e           sector_o
);

  localparam int unsigned F = FRAC_BITS;
  localparam int unsigned W = F + 7;

  logic [2:0] v_q;
  logic [2:0] adv;

  logic [2*F:0] hue_prod, sat_prod, val_prod;
  logic [F:0]   hue_s1_q, hue_s1_d, sat_s1_q, sat_s1_d, val_s1_q, val_s1_d;

  logic [F+9:0]   deg_prod;
  logic [2*F+1:0] chroma_prod;
  logic [DEG_W-1:0] deg_s2_q, deg_s2_d;
  logic [F:0]   chroma_s2_q, chroma_s2_d, base_s2_q, base_s2_d;

  logic [DEG_W-1:0]  deg_rem;
  logic [DEG_W-1:0]  deg_off;
  logic [SPAN_W-1:0] weight;
  logic [W-1:0]      prod_s3_q, prod_s3_d;
  logic [F:0]        chroma_s3_q, base_s3_q;
  hsvc_sector_e      sector_s3_q, sector_s3_d;

  always_comb begin
    adv[2] = !v_q[2] || ready_i;
    adv[1] = !v_q[1] || adv[2];
    adv[0] = !v_q[0] || adv[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= valid_i;
      if (adv[1]) v_q[1] <= v_q[0];
      if (adv[2]) v_q[2] <= v_q[1];
    end
  end

  always_comb begin
    hue_prod = {{(F+1){1'b0}}, draw_hue_i} * {{F{1'b0}}, hue_span_i};
    sat_prod = {{(F+1){1'b0}}, draw_sat_i} * {{F{1'b0}}, sat_span_i};
    val_prod = {{(F+1){1'b0}}, draw_value_i} * {{F{1'b0}}, val_span_i};
    hue_s1_d = hue_lo_i + hue_prod[2*F:F];
    sat_s1_d = sat_lo_i + sat_prod[2*F:F];
    val_s1_d = vary_i ? (val_lo_i + val_prod[2*F:F]) : val_top_i;
  end

  always_comb begin
    deg_prod    = {9'd0, hue_s1_q} * (F+10)'(DEG_360);
    chroma_prod = {{(F+1){1'b0}}, sat_s1_q} * {{(F+1){1'b0}}, val_s1_q};
    deg_s2_d    = deg_prod[F+DEG_W-1:F];
    chroma_s2_d = chroma_prod[2*F:F];
    base_s2_d   = val_s1_q - chroma_s2_d;
  end

  always_comb begin
    if (deg_s2_q < DEG_120) begin
      deg_rem = deg_s2_q;
    end else if (deg_s2_q < DEG_240) begin
      deg_rem = deg_s2_q - DEG_120;
    end else if (deg_s2_q < DEG_360) begin
      deg_rem = deg_s2_q - DEG_240;
    end else begin
      deg_rem = deg_s2_q - DEG_360;
    end
    deg_off   = (deg_rem >= DEG_60) ? (deg_rem - DEG_60) : (DEG_60 - deg_rem);
    weight    = SPAN_60 - deg_off[SPAN_W-1:0];
    prod_s3_d = {6'd0, chroma_s2_q} * {{(W-SPAN_W){1'b0}}, weight};
    if (deg_s2_q < DEG_60) begin
      sector_s3_d = SEC_RED_YELLOW;
    end else if (deg_s2_q < DEG_120) begin
      sector_s3_d = SEC_YELLOW_GREEN;
    end else if (deg_s2_q < DEG_180) begin
      sector_s3_d = SEC_GREEN_CYAN;
    end else if (deg_s2_q < DEG_240) begin
      sector_s3_d = SEC_CYAN_BLUE;
    end else if (deg_s2_q < DEG_300) begin
      sector_s3_d = SEC_BLUE_MAGENTA;
    end else begin
      sector_s3_d = SEC_MAGENTA_RED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      hue_s1_q <= hue_s1_d;
      sat_s1_q <= sat_s1_d;
      val_s1_q <= val_s1_d;
    end
    if (adv[1]) begin
      deg_s2_q    <= deg_s2_d;
      chroma_s2_q <= chroma_s2_d;
      base_s2_q   <= base_s2_d;
    end
    if (adv[2]) begin
      prod_s3_q   <= prod_s3_d;
      chroma_s3_q <= chroma_s2_q;
      base_s3_q   <= base_s2_q;
      sector_s3_q <= sector_s3_d;
    end
  end

  assign ready_o  = adv[0];
  assign valid_o  = v_q[2];
  assign prod_o   = prod_s3_q;
  assign chroma_o = chroma_s3_q;
  assign base_o   = base_s3_q;
  assign sector_o = sector_s3_q;

endmodule

/* hw/rtl/hsvc_back.sv */
// Back pipeline: divide by sixty, sector channel assembly and 8.8 scaling.
module hsvc_back
  import hsvc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [FRAC_BITS+6:0] prod_i,
  input  logic [FRAC_BITS:0]   chroma_i,
  input  logic [FRAC_BITS:0]   base_i,
  input  hsvc_sector_e         sector_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [CHAN_W-1:0]    red_o,
  output logic [CHAN_W-1:0]    green_o,
  output logic [CHAN_W-1:0]    blue_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned W  = F + 7;
  localparam int unsigned RW = W - 4;
  localparam int unsigned QW = F + 9;
  localparam int unsigned PW = F + 1 + CHAN_W;
  localparam longint unsigned RECIP_L = ((64'd1 << W) / 60) + 1;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  logic [2:0] v_q;
  logic [2:0] adv;

  logic [W+RW-1:0] est_s4_q, est_s4_d;
  logic [W-1:0]    prod_s4_q;
  logic [F:0]      chroma_s4_q, base_s4_q;
  hsvc_sector_e    sector_s4_q;

  logic [RW-1:0] quot_est;
  logic [QW-1:0] quot_back;
  logic [RW-1:0] quot_fix;
  logic [F:0]    x_term;
  logic [F:0]    red_s5_q, red_s5_d, green_s5_q, green_s5_d, blue_s5_q, blue_s5_d;

  logic [PW-1:0] red_s6_q, red_s6_d, green_s6_q, green_s6_d, blue_s6_q, blue_s6_d;

  always_comb begin
    adv[2] = !v_q[2] || ready_i;
    adv[1] = !v_q[1] || adv[2];
    adv[0] = !v_q[0] || adv[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= valid_i;
      if (adv[1]) v_q[1] <= v_q[0];
      if (adv[2]) v_q[2] <= v_q[1];
    end
  end

  assign est_s4_d = {{RW{1'b0}}, prod_i} * {{W{1'b0}}, RECIP};

  always_comb begin
    quot_est  = est_s4_q[W+RW-1:W];
    quot_back = {6'd0, quot_est} * QW'(SPAN_60);
    quot_fix  = (quot_back > {2'd0, prod_s4_q}) ? (quot_est - RW'(1)) : quot_est;
    x_term    = quot_fix[F:0];
    red_s5_d   = base_s4_q;
    green_s5_d = base_s4_q;
    blue_s5_d  = base_s4_q;
    case (sector_s4_q)
      SEC_RED_YELLOW: begin
        red_s5_d   = base_s4_q + chroma_s4_q;
        green_s5_d = base_s4_q + x_term;
      end
      SEC_YELLOW_GREEN: begin
        red_s5_d   = base_s4_q + x_term;
        green_s5_d = base_s4_q + chroma_s4_q;
      end
      SEC_GREEN_CYAN: begin
        green_s5_d = base_s4_q + chroma_s4_q;
        blue_s5_d  = base_s4_q + x_term;
      end
      SEC_CYAN_BLUE: begin
        green_s5_d = base_s4_q + x_term;
        blue_s5_d  = base_s4_q + chroma_s4_q;
      end
      SEC_BLUE_MAGENTA: begin
        red_s5_d   = base_s4_q + x_term;
        blue_s5_d  = base_s4_q + chroma_s4_q;
      end
      SEC_MAGENTA_RED: begin
        red_s5_d   = base_s4_q + chroma_s4_q;
        blue_s5_d  = base_s4_q + x_term;
      end
      default: ;
    endcase
  end

  always_comb begin
    red_s6_d   = {{CHAN_W{1'b0}}, red_s5_q} * PW'(CHAN_SCALE);
    green_s6_d = {{CHAN_W{1'b0}}, green_s5_q} * PW'(CHAN_SCALE);
    blue_s6_d  = {{CHAN_W{1'b0}}, blue_s5_q} * PW'(CHAN_SCALE);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      est_s4_q    <= est_s4_d;
      prod_s4_q   <= prod_i;
      chroma_s4_q <= chroma_i;
      base_s4_q   <= base_i;
      sector_s4_q <= sector_i;
    end
    if (adv[1]) begin
      red_s5_q   <= red_s5_d;
      green_s5_q <= green_s5_d;
      blue_s5_q  <= blue_s5_d;
    end
    if (adv[2]) begin
      red_s6_q   <= red_s6_d;
      green_s6_q <= green_s6_d;
      blue_s6_q  <= blue_s6_d;
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[2];
  assign red_o   = red_s6_q[F+CHAN_W-1:F];
  assign green_o = green_s6_q[F+CHAN_W-1:F];
  assign blue_o  = blue_s6_q[F+CHAN_W-1:F];

endmodule

/* hw/rtl/hsvc_checker.sv */
// Port-level checks for the colour generator top level, bound to every instance.
module hsvc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] red_o,
  input logic [15:0] green_o,
  input logic [15:0] blue_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled request dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_o <= 16'hFF00) && (green_o <= 16'hFF00) && (blue_o <= 16'hFF00))
    else $error("channel above full scale");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the receiver is free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("stalled colour changed");

endmodule

bind random_hsv_color_to_rgb_top hsvc_checker u_hsvc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .red_o      (red_o),
  .green_o    (green_o),
  .blue_o     (blue_o)
);
